// File: hw/rtl/lmc_pkg.sv
package lmc_pkg;

  localparam int HISTORY_DEPTH_DEF = 3;
  localparam int POS_WIDTH_DEF     = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_SOLID_LEN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN_LEN            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX_LEN            = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_SOLID_LEN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_DASH_TOLERANCE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_DASH_PAIR_LEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_DASH_SINGLE_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_WINDOW           = 3'd7;

  // Line count codes.
  localparam logic [2:0] COUNT_NONE  = 3'd0;
  localparam logic [2:0] COUNT_ONE   = 3'd1;
  localparam logic [2:0] COUNT_TWO   = 3'd2;
  localparam logic [2:0] COUNT_THREE = 3'd3;
  localparam logic [2:0] COUNT_CROSS = 3'd4;

  // Marking modes.
  localparam logic [2:0] MODE_SINGLE_SOLID   = 3'd0;
  localparam logic [2:0] MODE_SINGLE_DASHED  = 3'd1;
  localparam logic [2:0] MODE_DOUBLE_UNKNOWN = 3'd2;
  localparam logic [2:0] MODE_DOUBLE_DASHED  = 3'd3;
  localparam logic [2:0] MODE_TRIPLE_UNKNOWN = 3'd4;
  localparam logic [2:0] MODE_TRIPLE_SOLID   = 3'd5;
  localparam logic [2:0] MODE_TRIPLE_DASHED  = 3'd6;
  localparam logic [2:0] MODE_CROSS          = 3'd7;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FORCE  = 1'b1;

  typedef struct packed {
    logic [15:0] single_solid_len;
    logic [15:0] gap_min_len;
    logic [15:0] gap_max_len;
    logic [15:0] triple_solid_len;
    logic [15:0] triple_dash_tolerance;
    logic [15:0] double_dash_pair_len;
    logic [15:0] double_dash_single_len;
    logic [6:0]  steer_window;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    single_solid_len:       16'd288,
    gap_min_len:            16'd112,
    gap_max_len:            16'd144,
    triple_solid_len:       16'd160,
    triple_dash_tolerance:  16'd16,
    double_dash_pair_len:   16'd96,
    double_dash_single_len: 16'd208,
    steer_window:           7'd20
  };

  typedef struct packed {
    logic               req_type;
    logic [2:0]         raw_count;
    logic signed [31:0] odometer_pos;
    logic signed [7:0]  steer_angle;
    logic [2:0]         forced_mode;
  } req_t;

  typedef struct packed {
    logic [2:0]         filtered_count;
    logic [2:0]         marking_mode;
    logic signed [31:0] triple_run_len;
  } res_t;

  // Classified request handed from the front end to the rule engine.
  typedef struct packed {
    logic               force_mode;
    logic [2:0]         cur_count;
    logic [2:0]         prev_count;
    logic               straight;
    logic [2:0]         forced_mode;
    logic signed [31:0] odometer_pos;
  } item_t;

endpackage

// File: hw/rtl/lmc_fifo.sv
module lmc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = lmc_pkg::QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow : assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

// File: hw/rtl/lmc_front.sv
module lmc_front #(
  parameter int HISTORY_DEPTH = lmc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lmc_pkg::req_t       req,
  input  logic [6:0]          steer_window,
  output lmc_pkg::item_t      item
);

  logic [2:0] hist     [HISTORY_DEPTH];
  logic [2:0] hist_new [HISTORY_DEPTH];
  logic [2:0] accepted_count;
  logic [2:0] accepted_next;
  logic       same;
  logic signed [8:0] steer_x;
  logic signed [8:0] window_x;

  always_comb begin
    hist_new[0] = req.raw_count;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      hist_new[i] = hist[i-1];
    end
    same = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      if (hist_new[i] != hist_new[i+1]) begin
        same = 1'b0;
      end
    end
    accepted_next = same ? req.raw_count : accepted_count;
  end

  assign steer_x  = {req.steer_angle[7], req.steer_angle};
  assign window_x = $signed({2'b00, steer_window});

  always_comb begin
    item.force_mode   = (req.req_type == lmc_pkg::REQ_FORCE);
    item.prev_count   = accepted_count;
    item.cur_count    = item.force_mode ? accepted_count : accepted_next;
    item.straight     = (steer_x < window_x) && (steer_x > -window_x);
    item.forced_mode  = req.forced_mode;
    item.odometer_pos = req.odometer_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_count <= lmc_pkg::COUNT_NONE;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (accept && req.req_type == lmc_pkg::REQ_SAMPLE) begin
      accepted_count <= accepted_next;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= hist_new[i];
      end
    end
  end

endmodule

// File: hw/rtl/lmc_back.sv
module lmc_back #(
  parameter int POS_WIDTH = lmc_pkg::POS_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  lmc_pkg::item_t item,
  input  lmc_pkg::cfg_t  cfg,
  output lmc_pkg::res_t  res
);

  localparam int EXT_W = (POS_WIDTH > 32) ? POS_WIDTH : 32;

  typedef logic signed [POS_WIDTH-1:0] pos_t;
  typedef logic signed [POS_WIDTH:0]   cmp_t;

  pos_t       start [4];
  pos_t       rlen  [4];
  pos_t       start_n [4];
  pos_t       rlen_n  [4];
  logic [2:0] mode;
  logic [2:0] m;
  logic [EXT_W-1:0] odo_ext;
  logic [EXT_W-1:0] rl3_ext;
  pos_t       pos;
  cmp_t       diff;
  logic [2:0] cur;
  logic [2:0] prev;

  function automatic pos_t span(pos_t p, pos_t s);
    return p - s;
  endfunction

  function automatic cmp_t sx(pos_t v);
    return {v[POS_WIDTH-1], v};
  endfunction

  function automatic cmp_t zx(logic [15:0] v);
    return $signed({{(POS_WIDTH + 1 - 16){1'b0}}, v});
  endfunction

  assign odo_ext = EXT_W'(item.odometer_pos);
  assign pos     = odo_ext[POS_WIDTH-1:0];
  assign cur     = item.cur_count;
  assign prev    = item.prev_count;
  assign diff    = sx(rlen[1]) - sx(rlen[3]);

  // Rules run in order; each one sees the mode left by those above it.
  always_comb begin
    m = mode;
    for (int i = 0; i < 4; i++) begin
      start_n[i] = start[i];
      rlen_n[i]  = rlen[i];
    end
    if (item.force_mode) begin
      m = item.forced_mode;
    end else begin
      // single line
      if (prev != lmc_pkg::COUNT_ONE && cur == lmc_pkg::COUNT_ONE) begin
        start_n[1] = pos;
      end
      if (cur == lmc_pkg::COUNT_ONE) begin
        rlen_n[1] = span(pos, start_n[1]);
      end
      if (m != lmc_pkg::MODE_SINGLE_SOLID && cur == lmc_pkg::COUNT_ONE &&
          sx(rlen_n[1]) > zx(cfg.single_solid_len)) begin
        m = lmc_pkg::MODE_SINGLE_SOLID;
      end
      if (cur == lmc_pkg::COUNT_NONE && item.straight && prev == lmc_pkg::COUNT_ONE) begin
        start_n[0] = pos;
      end
      if (prev == lmc_pkg::COUNT_NONE && item.straight && cur == lmc_pkg::COUNT_ONE) begin
        rlen_n[0] = span(pos, start[0]);
        if (m == lmc_pkg::MODE_SINGLE_SOLID && sx(rlen_n[0]) > zx(cfg.gap_min_len) &&
            sx(rlen_n[0]) < zx(cfg.gap_max_len)) begin
          m = lmc_pkg::MODE_SINGLE_DASHED;
        end
      end
      // double line
      if (cur == lmc_pkg::COUNT_TWO && prev != lmc_pkg::COUNT_TWO) begin
        start_n[2] = pos;
        if (m == lmc_pkg::MODE_SINGLE_SOLID) begin
          m = lmc_pkg::MODE_DOUBLE_UNKNOWN;
        end
      end
      if (m == lmc_pkg::MODE_DOUBLE_UNKNOWN && cur == lmc_pkg::COUNT_ONE &&
          sx(rlen_n[1]) > zx(cfg.double_dash_single_len) &&
          sx(rlen[2]) > zx(cfg.double_dash_pair_len)) begin
        m = lmc_pkg::MODE_DOUBLE_DASHED;
      end
      if (prev == lmc_pkg::COUNT_TWO && cur != lmc_pkg::COUNT_TWO) begin
        rlen_n[2] = span(pos, start[2]);
      end
      // triple line; a new triple run never coincides with a single run update
      if (cur == lmc_pkg::COUNT_THREE && prev != lmc_pkg::COUNT_THREE) begin
        start_n[3] = pos;
        if (m == lmc_pkg::MODE_SINGLE_SOLID || m == lmc_pkg::MODE_DOUBLE_UNKNOWN) begin
          m = lmc_pkg::MODE_TRIPLE_UNKNOWN;
        end else if (m == lmc_pkg::MODE_TRIPLE_UNKNOWN) begin
          if (diff < zx(cfg.triple_dash_tolerance) &&
              diff > -zx(cfg.triple_dash_tolerance)) begin
            m = lmc_pkg::MODE_TRIPLE_DASHED;
          end
        end
      end
      if (cur == lmc_pkg::COUNT_THREE && m == lmc_pkg::MODE_TRIPLE_UNKNOWN) begin
        rlen_n[3] = span(pos, start_n[3]);
        if (sx(rlen_n[3]) > zx(cfg.triple_solid_len)) begin
          m = lmc_pkg::MODE_TRIPLE_SOLID;
        end
      end
      if (m == lmc_pkg::MODE_TRIPLE_UNKNOWN && cur != lmc_pkg::COUNT_THREE &&
          prev == lmc_pkg::COUNT_THREE) begin
        rlen_n[3] = span(pos, start[3]);
      end
      if (cur == lmc_pkg::COUNT_CROSS) begin
        m = lmc_pkg::MODE_CROSS;
      end
    end
  end

  assign rl3_ext            = EXT_W'(rlen_n[3]);
  assign res.filtered_count = cur;
  assign res.marking_mode   = m;
  assign res.triple_run_len = $signed(rl3_ext[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lmc_pkg::MODE_SINGLE_SOLID;
      for (int i = 0; i < 4; i++) begin
        start[i] <= '0;
        rlen[i]  <= '0;
      end
    end else if (take) begin
      mode <= m;
      for (int i = 0; i < 4; i++) begin
        start[i] <= start_n[i];
        rlen[i]  <= rlen_n[i];
      end
    end
  end

  a_force_mode : assert property (@(posedge clk) disable iff (rst)
    take && item.force_mode |=> mode == $past(item.forced_mode))
    else $error("forced mode not taken");
  a_cross_mode : assert property (@(posedge clk) disable iff (rst)
    take && !item.force_mode && item.cur_count == lmc_pkg::COUNT_CROSS
    |=> mode == lmc_pkg::MODE_CROSS)
    else $error("cross count did not give cross mode");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(mode))
    else $error("mode changed without a request");

endmodule

// File: hw/rtl/lane_marking_classifier.sv
// Path: a request accepted at a clock edge is registered in the middle queue;
// once the result queue has room, the rule engine takes it and its result is
// registered in the result queue, reaching the result ports when empty falls.
// Throughput: one request per cycle, sustained, while results are popped as fast.
// Each queue holds two entries; full and empty follow their fill counts.
// Reset (rst, synchronous, active high) empties both queues, clears the count
// history, run records and mode to single solid, and loads register defaults.
module lane_marking_classifier #(
  parameter int HISTORY_DEPTH = lmc_pkg::HISTORY_DEPTH_DEF,
  parameter int POS_WIDTH     = lmc_pkg::POS_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  lmc_pkg::req_t                    req,
  output logic                             empty,
  input  logic                             pop,
  output lmc_pkg::res_t                    res,
  input  logic                             cfg_we,
  input  logic [lmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // The front end filters the raw count and classifies each request; the
  // rule engine at the back applies the marking rules. A two-entry queue
  // sits between them and another in front of the result ports, so that a
  // stalled consumer does not stop the front end at once.

  lmc_pkg::cfg_t  cfg;
  lmc_pkg::item_t front_item;
  lmc_pkg::item_t mid_item;
  lmc_pkg::res_t  back_res;
  logic           accept;
  logic           mid_full;
  logic           mid_empty;
  logic           res_full;
  logic           take;

  // A request is taken whenever the middle queue has room.
  assign full   = mid_full;
  assign accept = push && !mid_full;

  // The rule engine works on the oldest classified request as soon as the
  // result queue can hold its answer.
  assign take = !mid_empty && !res_full;

  // Configuration register file. Every index of the port names a register,
  // and each write keeps only as many bits as its register has.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= lmc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lmc_pkg::CFG_SINGLE_SOLID_LEN:       cfg.single_solid_len       <= cfg_data;
        lmc_pkg::CFG_GAP_MIN_LEN:            cfg.gap_min_len            <= cfg_data;
        lmc_pkg::CFG_GAP_MAX_LEN:            cfg.gap_max_len            <= cfg_data;
        lmc_pkg::CFG_TRIPLE_SOLID_LEN:       cfg.triple_solid_len       <= cfg_data;
        lmc_pkg::CFG_TRIPLE_DASH_TOLERANCE:  cfg.triple_dash_tolerance  <= cfg_data;
        lmc_pkg::CFG_DOUBLE_DASH_PAIR_LEN:   cfg.double_dash_pair_len   <= cfg_data;
        lmc_pkg::CFG_DOUBLE_DASH_SINGLE_LEN: cfg.double_dash_single_len <= cfg_data;
        lmc_pkg::CFG_STEER_WINDOW:           cfg.steer_window           <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Front end: count agreement filter and steering window check.
  lmc_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req          (req),
    .steer_window (cfg.steer_window),
    .item         (front_item)
  );

  lmc_fifo #(
    .T     (lmc_pkg::item_t),
    .DEPTH (lmc_pkg::QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_item),
    .full  (mid_full),
    .pop   (take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // Back end: run tracking and the marking mode rules.
  lmc_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (mid_item),
    .cfg  (cfg),
    .res  (back_res)
  );

  lmc_fifo #(
    .T     (lmc_pkg::res_t),
    .DEPTH (lmc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop && !empty),
    .rdata (res),
    .empty (empty)
  );

endmodule
